// ----- rtl/stt_pkg.sv -----
// Package for the software timer table: command and result structs,
// opcode and status codes, and the link types shared by the cells.
// Depends on nothing.
`timescale 1ns / 1ps

package stt_pkg;

  localparam int TIMER_SLOTS_DEF = 16;
  localparam int RES_MAX         = 16;
  localparam int CNT_W           = $clog2(RES_MAX + 1);

  typedef enum logic [1:0] {
    OP_SET    = 2'd0,
    OP_UNSET  = 2'd1,
    OP_TICK   = 2'd2,
    OP_CANCEL = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_FIRED   = 2'd2,
    ST_NO_FIRE = 2'd3
  } status_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [15:0] event_id;
    logic [30:0] duration_ms;
    logic        periodic;
    logic [15:0] delta_ms;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] fired_event;
    logic        last;
  } out_item_t;

  // Token and search flag handed from one cell to the next.
  typedef struct packed {
    logic tok;
    logic srch;
  } stt_link_t;

  // Firing report of one cell, registered in the cycle after its visit.
  typedef struct packed {
    logic        fire;
    logic [15:0] ev;
  } stt_fire_t;

endpackage

// ----- rtl/stt_cell.sv -----
// One timer slot of the software timer table chain.
// Depends on stt_pkg.
`timescale 1ns / 1ps

module stt_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  stt_pkg::in_item_t cmd,
  input  stt_pkg::stt_link_t link_in,
  output stt_pkg::stt_link_t link_out,
  output stt_pkg::stt_fire_t fire_out
);
  import stt_pkg::*;

  logic        valid_r, valid_nxt;
  logic [15:0] event_r, event_nxt;
  logic [30:0] dur_r, dur_nxt;
  logic [31:0] elapsed_r, elapsed_nxt;
  logic        per_r, per_nxt;
  logic        tok_r;
  logic        srch_r, srch_nxt;
  logic        fire_r, fire_nxt;
  logic [15:0] fev_r;

  logic [32:0] sum;
  logic [31:0] sat;
  logic [32:0] diff;
  logic        reached;

  always_comb begin
    sum     = {1'b0, elapsed_r} + {17'b0, cmd.delta_ms};
    sat     = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    diff    = {1'b0, sat} - {2'b0, dur_r};
    reached = !diff[32];
  end

  always_comb begin
    valid_nxt   = valid_r;
    event_nxt   = event_r;
    dur_nxt     = dur_r;
    elapsed_nxt = elapsed_r;
    per_nxt     = per_r;
    srch_nxt    = link_in.srch;
    fire_nxt    = 1'b0;
    if (link_in.tok) begin
      unique case (cmd.opcode)
        OP_SET: begin
          if (link_in.srch && !valid_r) begin
            valid_nxt   = 1'b1;
            event_nxt   = cmd.event_id;
            dur_nxt     = cmd.duration_ms;
            elapsed_nxt = 32'd0;
            per_nxt     = cmd.periodic;
            srch_nxt    = 1'b0;
          end
        end
        OP_UNSET: begin
          if (link_in.srch && valid_r && event_r == cmd.event_id) begin
            valid_nxt = 1'b0;
            srch_nxt  = 1'b0;
          end
        end
        OP_TICK: begin
          if (valid_r) begin
            fire_nxt    = reached;
            elapsed_nxt = (reached && per_r) ? diff[31:0] : sat;
          end
        end
        OP_CANCEL: begin
          valid_nxt = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= 1'b0;
      fire_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      tok_r   <= link_in.tok;
      fire_r  <= fire_nxt;
    end
  end

  always_ff @(posedge clk) begin
    event_r   <= event_nxt;
    dur_r     <= dur_nxt;
    elapsed_r <= elapsed_nxt;
    per_r     <= per_nxt;
    srch_r    <= srch_nxt;
    fev_r     <= event_r;
  end

  assign link_out = '{tok: tok_r, srch: srch_r};
  assign fire_out = '{fire: fire_r, ev: fev_r};

endmodule

// ----- rtl/stt_ctrl.sv -----
// Controller of the software timer table: takes commands, launches the
// token down the cell chain and orders the results. Depends on stt_pkg.
`timescale 1ns / 1ps

module stt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  stt_pkg::in_item_t  in_item,
  output logic               busy,
  output stt_pkg::in_item_t  cmd,
  output stt_pkg::stt_link_t chain_head,
  input  stt_pkg::stt_link_t chain_end,
  input  stt_pkg::stt_fire_t fire,
  output logic               out_strobe,
  output stt_pkg::out_item_t out_result
);
  import stt_pkg::*;

  logic             busy_r, busy_nxt;
  logic             go_r;
  in_item_t         cmd_r;
  logic             end_r, srch_end_r;
  logic             held_v_r, held_v_nxt;
  logic [15:0]      held_ev_r, held_ev_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             strobe_r, strobe_nxt;
  out_item_t        res_r, res_nxt;
  logic             accept;

  assign accept = start && !busy_r;

  always_comb begin
    busy_nxt    = busy_r;
    held_v_nxt  = held_v_r;
    held_ev_nxt = held_ev_r;
    cnt_nxt     = cnt_r;
    strobe_nxt  = 1'b0;
    res_nxt     = res_r;
    if (accept) begin
      busy_nxt   = 1'b1;
      held_v_nxt = 1'b0;
      cnt_nxt    = '0;
    end else if (end_r) begin
      busy_nxt   = 1'b0;
      strobe_nxt = 1'b1;
      if (cmd_r.opcode == OP_TICK) begin
        if (held_v_r) begin
          res_nxt = '{status: ST_FIRED, fired_event: held_ev_r, last: 1'b1};
        end else begin
          res_nxt = '{status: ST_NO_FIRE, fired_event: 16'd0, last: 1'b1};
        end
      end else if (cmd_r.opcode == OP_SET && srch_end_r) begin
        res_nxt = '{status: ST_FULL, fired_event: 16'd0, last: 1'b1};
      end else begin
        res_nxt = '{status: ST_DONE, fired_event: 16'd0, last: 1'b1};
      end
    end else if (fire.fire && cnt_r < CNT_W'(RES_MAX)) begin
      // The held firing is known not to be the final one once another arrives.
      if (held_v_r) begin
        strobe_nxt = 1'b1;
        res_nxt    = '{status: ST_FIRED, fired_event: held_ev_r, last: 1'b0};
      end
      held_v_nxt  = 1'b1;
      held_ev_nxt = fire.ev;
      cnt_nxt     = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      go_r     <= 1'b0;
      end_r    <= 1'b0;
      held_v_r <= 1'b0;
      cnt_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      go_r     <= accept;
      end_r    <= chain_end.tok;
      held_v_r <= held_v_nxt;
      cnt_r    <= cnt_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_item;
    end
    srch_end_r <= chain_end.srch;
    held_ev_r  <= held_ev_nxt;
    res_r      <= res_nxt;
  end

  assign busy       = busy_r;
  assign cmd        = cmd_r;
  assign chain_head = '{tok: go_r, srch: 1'b1};
  assign out_strobe = strobe_r;
  assign out_result = res_r;

endmodule

// ----- rtl/software_timer_table.sv -----
// Top level of the software timer table: controller and a chain of slot cells.
// Depends on stt_pkg, stt_cell and stt_ctrl.
//
//   Channel  Ports                     Transfer
//   input    start, busy, in_item      rising edge with start high and busy low
//   result   out_strobe, out_result    every cycle in which out_strobe is high
//
// A token walks the chain one slot a cycle, from the controller's go_r
// through each slot's tok_r to end_r, after which the final result is
// registered; busy falls in the cycle that carries that result, and a new
// command may start then. Tick firings, at most RES_MAX of them, appear in
// slot order while the token walks, the last one marked. Reset is
// synchronous and empties every slot. The receiver cannot stall, so results never wait.
`timescale 1ns / 1ps

module software_timer_table #(
  parameter int TIMER_SLOTS = stt_pkg::TIMER_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  stt_pkg::in_item_t  in_item,
  output logic               busy,
  output logic               out_strobe,
  output stt_pkg::out_item_t out_result
);
  import stt_pkg::*;

  in_item_t  cmd;
  stt_link_t links [TIMER_SLOTS+1];
  stt_fire_t fires [TIMER_SLOTS];
  stt_fire_t fire_any;

  stt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_item    (in_item),
    .busy       (busy),
    .cmd        (cmd),
    .chain_head (links[0]),
    .chain_end  (links[TIMER_SLOTS]),
    .fire       (fire_any),
    .out_strobe (out_strobe),
    .out_result (out_result)
  );

  for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
    stt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .link_in  (links[i]),
      .link_out (links[i+1]),
      .fire_out (fires[i])
    );
  end

  // Only the cell visited in the previous cycle can report a firing.
  always_comb begin
    fire_any = '0;
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      if (fires[i].fire) begin
        fire_any.fire = 1'b1;
        fire_any.ev   = fire_any.ev | fires[i].ev;
      end
    end
  end

endmodule
